FILE: rtl/drt_pkg.sv
// Package with payload types, action and result codes, and limits for the request tracker.
package drt_pkg;

    localparam int PendingDepth = 8;
    localparam int RecentDepth  = 16;

    localparam logic [11:0] WinLo     = 12'd200;
    localparam logic [11:0] WinHi     = 12'd3000;
    localparam logic [7:0]  MaxKeyLen = 8'd96;

    localparam logic [2:0] ActRequest  = 3'd0;
    localparam logic [2:0] ActMatch    = 3'd1;
    localparam logic [2:0] ActComplete = 3'd2;
    localparam logic [2:0] ActExpire   = 3'd3;
    localparam logic [2:0] ActClear    = 3'd4;

    localparam logic [2:0] KindRejected  = 3'd0;
    localparam logic [2:0] KindDuplicate = 3'd1;
    localparam logic [2:0] KindConfirmed = 3'd2;
    localparam logic [2:0] KindPending   = 3'd3;
    localparam logic [2:0] KindCompleted = 3'd4;
    localparam logic [2:0] KindDone      = 3'd5;

    localparam logic [1:0] RegMatchWindow = 2'd0;
    localparam logic [1:0] RegFlowWindow  = 2'd1;
    localparam logic [1:0] RegFreshAge    = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] now_ms;
        logic [63:0] flow_key;
        logic [7:0]  flow_key_length;
        logic [63:0] cause_key;
        logic [7:0]  cause_key_length;
        logic        owner_present;
        logic [63:0] last_match_ms;
        logic [31:0] tag;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] out_flow_key;
        logic [63:0] out_cause_key;
        logic [63:0] out_req_ms;
        logic [31:0] out_tag;
        logic        last;
        logic        needs_sample;
    } t_rsp;

endpackage

FILE: rtl/deadline_request_tracker_top.sv
// Top level of the deadline request tracker: table, recent-key ring and scan sequencer.
// A request runs table scan, ring scan, decide, sample-flag scan and output, one entry
// compared per cycle by the shared 64-bit comparator. Events walk the table one entry a
// cycle and each removal shifts later entries down one a cycle; a complete also rescans the
// flag per completed entry, and output stalls add to both. o_in_stall is low only when
// idle, and reset (synchronous, active low) empties table and ring and loads register defaults.
module deadline_request_tracker_top #(
    parameter int PENDING_DEPTH = drt_pkg::PendingDepth,
    parameter int RECENT_DEPTH  = drt_pkg::RecentDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  drt_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output drt_pkg::t_rsp  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [11:0]    i_cfg_data
);
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PC = $clog2(PENDING_DEPTH + 1);
    localparam int RW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int RC = $clog2(RECENT_DEPTH + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSCAN  = 4'd1;  // compare request key with table entries
    localparam logic [3:0] S_RSCAN  = 4'd2;  // compare request key with ring entries
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_EVSCAN = 4'd4;  // walk table for match, complete or expire
    localparam logic [3:0] S_SHIFT  = 4'd5;  // move later entries down one place
    localparam logic [3:0] S_NSCAN  = 4'd6;  // compute the sample flag
    localparam logic [3:0] S_OUT    = 4'd7;  // hold a result until taken

    // The closing result of an event, before the flag and last bit are filled in.
    localparam drt_pkg::t_rsp RSP_DONE = '{kind: drt_pkg::KindDone, default: '0};

    // Table storage; each entry is one row.
    logic [63:0] r_fk [PENDING_DEPTH];
    logic [63:0] r_ck [PENDING_DEPTH];
    logic [63:0] r_rq [PENDING_DEPTH];
    logic [63:0] r_md [PENDING_DEPTH];
    logic [63:0] r_fd [PENDING_DEPTH];
    logic [31:0] r_tg [PENDING_DEPTH];
    logic        r_mt [PENDING_DEPTH];
    logic [63:0] r_rk [RECENT_DEPTH];

    logic [PC-1:0] r_pcnt;
    logic [RC-1:0] r_rcnt;
    logic [RW-1:0] r_rptr;
    logic [11:0]   r_mwin, r_fwin, r_fage;

    logic [3:0]    r_state;
    drt_pkg::t_req r_req;
    logic [PC-1:0] r_idx;     // scan index, wide enough to hold the count
    logic [RC-1:0] r_ridx;
    logic [PC-1:0] r_sidx;    // shift index
    logic          r_hit;
    logic          r_evpend;  // a completed entry is being output
    drt_pkg::t_rsp r_out;

    // Effective windows, clamped as configured.
    logic [11:0] w_m, w_f, w_a, w_mc, w_fc;
    always_comb begin
        w_mc = (r_mwin > drt_pkg::WinHi) ? drt_pkg::WinHi : r_mwin;
        w_m  = (w_mc < drt_pkg::WinLo) ? drt_pkg::WinLo : w_mc;
        w_fc = (r_fwin > drt_pkg::WinHi) ? drt_pkg::WinHi : r_fwin;
        w_f  = (w_fc < w_m) ? w_m : w_fc;
        w_a  = (r_fage < w_m) ? r_fage : w_m;
    end

    // The single shared comparator: one 64-bit operand pair per cycle.
    logic [63:0] w_ca, w_cb;
    logic        w_eq, w_le;
    logic [PW-1:0] w_pi;
    logic [RW-1:0] w_ri;
    assign w_pi = r_idx[PW-1:0];
    assign w_ri = r_ridx[RW-1:0];
    always_comb begin
        w_ca = r_req.now_ms;
        w_cb = r_md[w_pi];
        case (r_state)
            S_PSCAN: begin
                w_ca = r_req.flow_key;
                w_cb = r_fk[w_pi];
            end
            S_RSCAN: begin
                w_ca = r_req.flow_key;
                w_cb = r_rk[w_ri];
            end
            S_EVSCAN: begin
                w_ca = r_req.now_ms;
                w_cb = (r_req.action == drt_pkg::ActComplete) ? r_fd[w_pi] : r_md[w_pi];
            end
            default: begin
                w_ca = r_req.now_ms;
                w_cb = r_md[w_pi];
            end
        endcase
    end
    assign w_eq = (w_ca == w_cb);
    assign w_le = (w_ca <= w_cb);

    // Deadline arithmetic for a new entry and the fresh-match test.
    logic [64:0] w_mds, w_fds;
    logic [63:0] w_age;
    logic        w_fresh, w_badlen;
    assign w_mds = {1'b0, r_req.now_ms} + {53'd0, w_m};
    assign w_fds = {1'b0, r_req.now_ms} + {53'd0, w_f};
    assign w_age = r_req.now_ms - r_req.last_match_ms;
    assign w_fresh = r_req.owner_present && (r_req.last_match_ms != 64'd0)
        && (r_req.now_ms >= r_req.last_match_ms) && (w_age <= {52'd0, w_a});
    assign w_badlen = (r_req.flow_key_length == 8'd0)
        || (r_req.flow_key_length > drt_pkg::MaxKeyLen)
        || (r_req.cause_key_length == 8'd0)
        || (r_req.cause_key_length > drt_pkg::MaxKeyLen);

    // Expire needs both deadlines; both are checked directly, outside the shared comparator.
    logic w_stale;
    assign w_stale = (r_req.now_ms > r_fd[w_pi])
        || (!r_mt[w_pi] && (r_req.now_ms > r_md[w_pi]));

    logic w_pend_end;
    assign w_pend_end = (r_idx >= r_pcnt);

    logic w_take;
    assign w_take = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    logic w_rem;   // remember a key this cycle
    logic [63:0] w_remkey;

    always_comb begin
        w_rem    = 1'b0;
        w_remkey = r_req.flow_key;
        if (r_state == S_DECIDE && !w_badlen && !r_hit && w_fresh) begin
            w_rem = 1'b1;
        end
        if (r_state == S_EVSCAN && !w_pend_end) begin
            if (r_req.action == drt_pkg::ActComplete && r_mt[w_pi] && w_le) begin
                w_rem    = 1'b1;
                w_remkey = r_fk[w_pi];
            end
            if (r_req.action == drt_pkg::ActExpire && w_stale) begin
                w_rem    = 1'b1;
                w_remkey = r_fk[w_pi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pcnt   <= '0;
            r_rcnt   <= '0;
            r_rptr   <= '0;
            r_mwin   <= 12'd1000;
            r_fwin   <= 12'd3000;
            r_fage   <= 12'd1000;
            r_evpend <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    drt_pkg::RegMatchWindow: r_mwin <= i_cfg_data;
                    drt_pkg::RegFlowWindow:  r_fwin <= i_cfg_data;
                    drt_pkg::RegFreshAge:    r_fage <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_rem) begin
                r_rk[r_rptr] <= w_remkey;
                r_rptr <= (r_rptr == RW'(RECENT_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                if (r_rcnt < RC'(RECENT_DEPTH)) r_rcnt <= r_rcnt + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_req  <= i_in_data;
                        r_idx  <= '0;
                        r_ridx <= '0;
                        r_hit  <= 1'b0;
                        r_out  <= RSP_DONE;
                        if (i_in_data.action == drt_pkg::ActRequest) begin
                            r_state <= S_PSCAN;
                        end else if (i_in_data.action == drt_pkg::ActClear) begin
                            r_pcnt  <= '0;
                            r_rcnt  <= '0;
                            r_rptr  <= '0;
                            r_state <= S_NSCAN;
                        end else if (i_in_data.action == drt_pkg::ActMatch
                                     || i_in_data.action == drt_pkg::ActExpire
                                     || (i_in_data.action == drt_pkg::ActComplete
                                         && i_in_data.owner_present)) begin
                            r_state <= S_EVSCAN;
                        end else begin
                            r_state <= S_NSCAN;
                        end
                    end
                end
                S_PSCAN: begin
                    if (w_pend_end) begin
                        r_state <= S_RSCAN;
                    end else begin
                        if (w_eq) r_hit <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_RSCAN: begin
                    if (r_ridx >= r_rcnt) begin
                        r_state <= S_DECIDE;
                    end else begin
                        if (w_eq) r_hit <= 1'b1;
                        r_ridx <= r_ridx + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_idx   <= '0;
                    r_state <= S_NSCAN;
                    if (w_badlen) begin
                        r_out.kind <= drt_pkg::KindRejected;
                    end else if (r_hit) begin
                        r_out.kind <= drt_pkg::KindDuplicate;
                    end else if (w_fresh) begin
                        r_out.kind <= drt_pkg::KindConfirmed;
                    end else if (r_pcnt >= PC'(PENDING_DEPTH)) begin
                        r_out.kind <= drt_pkg::KindRejected;
                    end else begin
                        r_fk[r_pcnt[PW-1:0]] <= r_req.flow_key;
                        r_ck[r_pcnt[PW-1:0]] <= r_req.cause_key;
                        r_rq[r_pcnt[PW-1:0]] <= r_req.now_ms;
                        r_md[r_pcnt[PW-1:0]] <= w_mds[64] ? '1 : w_mds[63:0];
                        r_fd[r_pcnt[PW-1:0]] <= w_fds[64] ? '1 : w_fds[63:0];
                        r_tg[r_pcnt[PW-1:0]] <= r_req.tag;
                        r_mt[r_pcnt[PW-1:0]] <= 1'b0;
                        r_pcnt <= r_pcnt + 1'b1;
                        r_out.kind <= drt_pkg::KindPending;
                    end
                end
                S_EVSCAN: begin
                    if (w_pend_end) begin
                        r_idx   <= '0;
                        r_out   <= RSP_DONE;
                        r_state <= S_NSCAN;
                    end else if (r_req.action == drt_pkg::ActMatch) begin
                        if (w_le) r_mt[w_pi] <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else if (w_rem) begin
                        r_sidx <= r_idx + 1'b1;
                        if (r_req.action == drt_pkg::ActComplete) begin
                            r_out.kind          <= drt_pkg::KindCompleted;
                            r_out.out_flow_key  <= r_fk[w_pi];
                            r_out.out_cause_key <= r_ck[w_pi];
                            r_out.out_req_ms    <= r_rq[w_pi];
                            r_out.out_tag       <= r_tg[w_pi];
                            r_evpend            <= 1'b1;
                        end
                        r_state <= S_SHIFT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // Entry r_sidx moves to r_sidx-1; the count drops when done.
                    if (r_sidx >= r_pcnt) begin
                        r_pcnt  <= r_pcnt - 1'b1;
                        r_state <= r_evpend ? S_NSCAN : S_EVSCAN;
                        // A completed entry needs a full flag scan from the first entry.
                        if (r_evpend) r_idx <= '0;
                    end else begin
                        r_fk[PW'(r_sidx - 1'b1)] <= r_fk[r_sidx[PW-1:0]];
                        r_ck[PW'(r_sidx - 1'b1)] <= r_ck[r_sidx[PW-1:0]];
                        r_rq[PW'(r_sidx - 1'b1)] <= r_rq[r_sidx[PW-1:0]];
                        r_md[PW'(r_sidx - 1'b1)] <= r_md[r_sidx[PW-1:0]];
                        r_fd[PW'(r_sidx - 1'b1)] <= r_fd[r_sidx[PW-1:0]];
                        r_tg[PW'(r_sidx - 1'b1)] <= r_tg[r_sidx[PW-1:0]];
                        r_mt[PW'(r_sidx - 1'b1)] <= r_mt[r_sidx[PW-1:0]];
                        r_sidx <= r_sidx + 1'b1;
                    end
                end
                S_NSCAN: begin
                    if (w_pend_end) begin
                        // An empty table leaves no scan to set the flag.
                        r_out.needs_sample <= (r_idx == '0) ? 1'b0 : r_hit;
                        r_out.last         <= !r_evpend;
                        r_state            <= S_OUT;
                    end else begin
                        if (r_idx == '0) r_hit <= !r_mt[w_pi] && w_le;
                        else if (!r_mt[w_pi] && w_le) r_hit <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (r_evpend) begin
                            r_evpend <= 1'b0;
                            r_idx    <= '0;
                            r_out    <= '0;
                            r_state  <= S_EVSCAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/drt_checker.sv
// Port-level checker for the deadline request tracker, bound to the top level.
module drt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input drt_pkg::t_rsp o_out_data,
    input logic          o_cfg_ready
);
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("result shown while idle");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_in_stall) else $error("config open while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data)) else $error("result changed");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == drt_pkg::KindDone |-> o_out_data.last)
        else $error("done without last");
    a_comp_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == drt_pkg::KindCompleted |-> !o_out_data.last)
        else $error("completed marked last");
endmodule

bind deadline_request_tracker_top drt_checker u_drt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
    .o_cfg_ready(o_cfg_ready)
);
